// ===== hw/rtl/tgar_pkg.sv =====
`default_nettype none

package tgar_pkg;

  // Field widths of the input word, the result word and the tileset words.
  localparam int GID_W      = 16;
  localparam int COLS_W     = 8;
  localparam int PIX_W      = 8;
  localparam int SRC_X_W    = 16;
  localparam int SRC_Y_W    = 24;
  localparam int OUT_IDX_W  = 2;
  localparam int WORD_W     = 40;
  localparam int IN_USE_W   = 3;

  // Tileset index carried through the pipeline; covers up to eight tilesets.
  localparam int SEL_IDX_W  = 3;

  // One divider cell resolves one quotient bit of the local id.
  localparam int DIV_STEPS  = GID_W;

  // Default number of tilesets.
  localparam int NUM_TILESETS_DEF = 4;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_RESOLVED  = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NO_MATCH  = 2'd2,
    ST_ZERO_COLS = 2'd3
  } status_t;

  // Running best match handed along the selection cells.
  typedef struct packed {
    logic [GID_W-1:0]     gid;
    logic                 found;
    logic [SEL_IDX_W-1:0] idx;
    logic [GID_W-1:0]     first;
    logic [COLS_W-1:0]    cols;
    logic [PIX_W-1:0]     tw;
    logic [PIX_W-1:0]     th;
  } sel_t;

  // Partial division handed along the divider cells.
  typedef struct packed {
    status_t              status;
    logic [SEL_IDX_W-1:0] idx;
    logic [COLS_W-1:0]    cols;
    logic [PIX_W-1:0]     tw;
    logic [PIX_W-1:0]     th;
    logic [GID_W-1:0]     num;
    logic [COLS_W-1:0]    rem;
  } div_t;

  // Field extraction from a packed tileset word.
  function automatic logic [GID_W-1:0] ts_first(input logic [WORD_W-1:0] w);
    ts_first = w[15:0];
  endfunction

  function automatic logic [COLS_W-1:0] ts_cols(input logic [WORD_W-1:0] w);
    ts_cols = w[23:16];
  endfunction

  function automatic logic [PIX_W-1:0] ts_tw(input logic [WORD_W-1:0] w);
    ts_tw = w[31:24];
  endfunction

  function automatic logic [PIX_W-1:0] ts_th(input logic [WORD_W-1:0] w);
    ts_th = w[39:32];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tile_gid_to_atlas_rect.sv =====
`default_nettype none

// Channel   Ports                                      Handshake
// input     in_tile_gid                                start high, busy low
// result    out_status, out_tileset_index, out_source_x,
//           out_source_y, out_rect_width, out_rect_height  out_strobe, one cycle
// config    cfg_index, cfg_wdata                       cfg_we
//
// A new word is taken in every cycle; busy is never raised.
// Each word passes through one tileset cell per tileset, the setup register,
// sixteen divider cells and the scaling register before it leaves.
// Reset clears the configuration and drops every word in flight.
// The receiver cannot stall, so the pipeline never holds.

module tile_gid_to_atlas_rect #(
  parameter int NUM_TILESETS = tgar_pkg::NUM_TILESETS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [tgar_pkg::GID_W-1:0]            in_tile_gid,
  output logic                                       out_strobe,
  output logic [1:0]                                 out_status,
  output logic [tgar_pkg::OUT_IDX_W-1:0]             out_tileset_index,
  output logic [tgar_pkg::SRC_X_W-1:0]               out_source_x,
  output logic [tgar_pkg::SRC_Y_W-1:0]               out_source_y,
  output logic [tgar_pkg::PIX_W-1:0]                 out_rect_width,
  output logic [tgar_pkg::PIX_W-1:0]                 out_rect_height,
  input  wire logic                                  cfg_we,
  input  wire logic [$clog2(NUM_TILESETS+1)-1:0]     cfg_index,
  input  wire logic [tgar_pkg::WORD_W-1:0]           cfg_wdata
);
  import tgar_pkg::*;

  localparam int CFG_IDX_W = $clog2(NUM_TILESETS + 1);
  localparam int LATENCY   = NUM_TILESETS + DIV_STEPS + 2;

  logic [WORD_W-1:0]   ts_word_r [NUM_TILESETS];
  logic [IN_USE_W-1:0] in_use_r;

  logic sel_v [NUM_TILESETS+1];
  sel_t sel_c [NUM_TILESETS+1];
  logic div_v [DIV_STEPS+1];
  div_t div_c [DIV_STEPS+1];

  logic prep_v_r;
  div_t prep_r;
  div_t prep_nxt;
  sel_t last_sel;

  // Every word is taken as it comes.
  assign busy = 1'b0;

  // Tileset registers.
  for (genvar k = 0; k < NUM_TILESETS; k++) begin : g_ts
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ts_word_r[k] <= '0;
      end else if (cfg_we && (cfg_index == CFG_IDX_W'(k))) begin
        ts_word_r[k] <= cfg_wdata;
      end
    end
  end

  // Count of tilesets in use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r <= '0;
    end else if (cfg_we && (cfg_index == CFG_IDX_W'(NUM_TILESETS))) begin
      in_use_r <= cfg_wdata[IN_USE_W-1:0];
    end
  end

  // Head of the selection chain: no match yet.
  always_comb begin
    sel_v[0]       = start && !busy;
    sel_c[0]       = '0;
    sel_c[0].gid   = in_tile_gid;
  end

  // Selection chain, one cell per tileset.
  for (genvar k = 0; k < NUM_TILESETS; k++) begin : g_sel
    tgar_sel_cell #(.CELL_IDX(k)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_use  (in_use_r),
      .word    (ts_word_r[k]),
      .i_valid (sel_v[k]),
      .i_sel   (sel_c[k]),
      .o_valid (sel_v[k+1]),
      .o_sel   (sel_c[k+1])
    );
  end

  // Setup: settle the status and form the local id as the dividend.
  always_comb begin
    last_sel        = sel_c[NUM_TILESETS];
    prep_nxt        = '0;
    prep_nxt.idx    = last_sel.idx;
    prep_nxt.cols   = last_sel.cols;
    prep_nxt.tw     = last_sel.tw;
    prep_nxt.th     = last_sel.th;
    prep_nxt.num    = last_sel.gid - last_sel.first;
    prep_nxt.rem    = '0;
    if (last_sel.gid == '0) begin
      prep_nxt.status = ST_EMPTY;
    end else if (!last_sel.found) begin
      prep_nxt.status = ST_NO_MATCH;
    end else if (last_sel.cols == '0) begin
      prep_nxt.status = ST_ZERO_COLS;
    end else begin
      prep_nxt.status = ST_RESOLVED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_v_r <= 1'b0;
    end else begin
      prep_v_r <= sel_v[NUM_TILESETS];
    end
  end

  always_ff @(posedge clk) begin
    prep_r <= prep_nxt;
  end

  assign div_v[0] = prep_v_r;
  assign div_c[0] = prep_r;

  // Divider chain, one quotient bit per cell.
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    tgar_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (div_v[j]),
      .i_div   (div_c[j]),
      .o_valid (div_v[j+1]),
      .o_div   (div_c[j+1])
    );
  end

  // Pixel scaling and the result register.
  tgar_scale u_scale (
    .clk             (clk),
    .rst_n           (rst_n),
    .i_valid         (div_v[DIV_STEPS]),
    .i_div           (div_c[DIV_STEPS]),
    .o_strobe        (out_strobe),
    .o_status        (out_status),
    .o_tileset_index (out_tileset_index),
    .o_source_x      (out_source_x),
    .o_source_y      (out_source_y),
    .o_rect_width    (out_rect_width),
    .o_rect_height   (out_rect_height)
  );

`ifndef SYNTHESIS
  a_word_leaves: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_strobe)
    else $error("accepted word did not leave on time");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

  a_unresolved_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != ST_RESOLVED)) |->
      ((out_tileset_index == '0) && (out_source_x == '0) && (out_source_y == '0) &&
       (out_rect_width == '0) && (out_rect_height == '0)))
    else $error("unresolved result carries nonzero fields");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tgar_sel_cell.sv =====
`default_nettype none

module tgar_sel_cell #(
  parameter int CELL_IDX = 0
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [tgar_pkg::IN_USE_W-1:0]    in_use,
  input  wire logic [tgar_pkg::WORD_W-1:0]      word,
  input  wire logic                             i_valid,
  input  wire tgar_pkg::sel_t                   i_sel,
  output logic                                  o_valid,
  output tgar_pkg::sel_t                        o_sel
);
  import tgar_pkg::*;

  logic [GID_W-1:0] first;
  logic             hit;
  logic             valid_r;
  sel_t             sel_r;
  sel_t             sel_nxt;

  // Take this tileset over the running best when it is in use, its first id
  // is not above the gid, and nothing has matched yet or that id is strictly larger than the best so far.
  always_comb begin
    first   = ts_first(word);
    hit     = (in_use > IN_USE_W'(CELL_IDX)) && (first <= i_sel.gid) &&
              (!i_sel.found || (first > i_sel.first));
    sel_nxt = i_sel;
    if (hit) begin
      sel_nxt.found = 1'b1;
      sel_nxt.idx   = SEL_IDX_W'(CELL_IDX);
      sel_nxt.first = first;
      sel_nxt.cols  = ts_cols(word);
      sel_nxt.tw    = ts_tw(word);
      sel_nxt.th    = ts_th(word);
    end
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= i_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    sel_r <= sel_nxt;
  end

  assign o_valid = valid_r;
  assign o_sel   = sel_r;

`ifndef SYNTHESIS
  a_found_not_above_gid: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid && o_sel.found) |-> (o_sel.first <= o_sel.gid))
    else $error("selected first id above gid");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tgar_div_cell.sv =====
`default_nettype none

module tgar_div_cell (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           i_valid,
  input  wire tgar_pkg::div_t i_div,
  output logic                o_valid,
  output tgar_pkg::div_t      o_div
);
  import tgar_pkg::*;

  logic [COLS_W:0] trial;
  logic            ge;
  logic            valid_r;
  div_t            div_r;
  div_t            div_nxt;

  // One restoring division step: bring down the next dividend bit and
  // subtract the column count when it fits; the quotient bit shifts in low.
  always_comb begin
    trial   = {i_div.rem, i_div.num[GID_W-1]};
    ge      = (trial >= {1'b0, i_div.cols});
    div_nxt = i_div;
    div_nxt.num = {i_div.num[GID_W-2:0], ge};
    if (ge) begin
      div_nxt.rem = COLS_W'(trial - {1'b0, i_div.cols});
    end else begin
      div_nxt.rem = trial[COLS_W-1:0];
    end
  end

  // Valid flag of the stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= i_valid;
    end
  end

  // Payload of the stage.
  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

  assign o_valid = valid_r;
  assign o_div   = div_r;

`ifndef SYNTHESIS
  a_rem_below_cols: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid && (o_div.cols != '0)) |-> (o_div.rem < o_div.cols))
    else $error("partial remainder not below column count");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/tgar_scale.sv =====
`default_nettype none

module tgar_scale (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            i_valid,
  input  wire tgar_pkg::div_t                  i_div,
  output logic                                 o_strobe,
  output logic [1:0]                           o_status,
  output logic [tgar_pkg::OUT_IDX_W-1:0]       o_tileset_index,
  output logic [tgar_pkg::SRC_X_W-1:0]         o_source_x,
  output logic [tgar_pkg::SRC_Y_W-1:0]         o_source_y,
  output logic [tgar_pkg::PIX_W-1:0]           o_rect_width,
  output logic [tgar_pkg::PIX_W-1:0]           o_rect_height
);
  import tgar_pkg::*;

  logic                 strobe_r;
  status_t              status_r;
  status_t              status_nxt;
  logic [OUT_IDX_W-1:0] idx_r;
  logic [OUT_IDX_W-1:0] idx_nxt;
  logic [SRC_X_W-1:0]   x_r;
  logic [SRC_X_W-1:0]   x_nxt;
  logic [SRC_Y_W-1:0]   y_r;
  logic [SRC_Y_W-1:0]   y_nxt;
  logic [PIX_W-1:0]     w_r;
  logic [PIX_W-1:0]     w_nxt;
  logic [PIX_W-1:0]     h_r;
  logic [PIX_W-1:0]     h_nxt;

  // Column and row scaled to pixels; unresolved words carry zeros.
  always_comb begin
    status_nxt = i_div.status;
    idx_nxt    = '0;
    x_nxt      = '0;
    y_nxt      = '0;
    w_nxt      = '0;
    h_nxt      = '0;
    if (i_div.status == ST_RESOLVED) begin
      idx_nxt = i_div.idx[OUT_IDX_W-1:0];
      x_nxt   = SRC_X_W'({8'd0, i_div.rem} * {8'd0, i_div.tw});
      y_nxt   = SRC_Y_W'({8'd0, i_div.num} * {16'd0, i_div.th});
      w_nxt   = i_div.tw;
      h_nxt   = i_div.th;
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= i_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    w_r      <= w_nxt;
    h_r      <= h_nxt;
  end

  assign o_strobe        = strobe_r;
  assign o_status        = status_r;
  assign o_tileset_index = idx_r;
  assign o_source_x      = x_r;
  assign o_source_y      = y_r;
  assign o_rect_width    = w_r;
  assign o_rect_height   = h_r;

endmodule

`default_nettype wire
